/* design/ptel_pkg.sv */
// ptel_pkg: shared constants and types of the rail power telemetry block
// used by the store, the average datapath and the top level
package ptel_pkg;

  localparam int RAIL_COUNT    = 8;
  localparam int AVG_FRAC_BITS = 16;
  localparam int EMA_WEIGHT    = 6554;
  localparam int EMA_SHIFT     = 16;

  localparam int RAIL_IDX_W = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;
  localparam int POWER_W    = 32;
  localparam int PEAK_W     = 31;
  localparam int AVG_W      = POWER_W + AVG_FRAC_BITS;
  localparam int DIFF_W     = AVG_W + 1;
  localparam int WEIGHT_W   = $clog2(EMA_WEIGHT + 1);
  localparam int HI_W       = DIFF_W - EMA_SHIFT;
  localparam int HI_PROD_W  = HI_W + WEIGHT_W + 1;
  localparam int LO_PROD_W  = EMA_SHIFT + WEIGHT_W;

  typedef logic [RAIL_IDX_W-1:0]     rail_idx_t;
  typedef logic signed [AVG_W-1:0]   avg_t;
  typedef logic [PEAK_W-1:0]         peak_t;
  typedef logic signed [POWER_W-1:0] power_t;

  // step enables of the average datapath
  typedef struct packed {
    logic mul;
    logic diff;
    logic scale;
  } stage_t;

  typedef struct packed {
    logic [2:0]         rail_out;
    logic signed [15:0] current_quarter_ma;
    logic signed [15:0] voltage_mv;
    power_t             power_now;
    power_t             power_average;
    peak_t              power_peak;
  } result_t;

endpackage

/* design/ptel_if.sv */
// ptel_if: valid/ready channel interfaces for reading pairs and results
// depends on ptel_pkg for the power and peak types
interface ptel_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         rail;
  logic signed [15:0] shunt_sample;
  logic signed [15:0] bus_sample;

  modport source (output valid, output rail, output shunt_sample, output bus_sample,
                  input ready);
  modport sink (input valid, input rail, input shunt_sample, input bus_sample,
                output ready);
endinterface

interface ptel_out_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           rail_out;
  logic signed [15:0]   current_quarter_ma;
  logic signed [15:0]   voltage_mv;
  ptel_pkg::power_t     power_now;
  ptel_pkg::power_t     power_average;
  ptel_pkg::peak_t      power_peak;

  modport source (output valid, output rail_out, output current_quarter_ma,
                  output voltage_mv, output power_now, output power_average,
                  output power_peak, input ready);
  modport sink (input valid, input rail_out, input current_quarter_ma,
                input voltage_mv, input power_now, input power_average,
                input power_peak, output ready);
endinterface

/* design/rail_power_telemetry.sv */
// rail_power_telemetry: top level of the per-rail power monitor
// depends on ptel_pkg, ptel_if, ptel_store and ptel_ema
//
// usage
//   in_i carries one reading pair per transfer: rail index, signed shunt
//   reading (0.25 mA units) and signed bus reading (mV). out_o returns one
//   result per input transfer, in order: the echoed fields, the instant
//   power shunt*bus (0.25 uW units), the rail's updated exponential average
//   (weight 6554/65536, integer part rounded toward minus infinity) and the
//   rail's peak power since reset.
//   a result is loaded into the output register in the write-back step,
//   after the read, difference and scale steps. The per-rail store is
//   read, modified and written back for each item (read, difference, two
//   weight multiplies, sum and write back), one item in flight at a time.
//   in_i.ready is high only while the sequencer is idle; a result may still
//   wait in the output register while the next item is taken.
//   if the receiver stalls, the item in flight holds in its write-back step
//   until the output register frees up; nothing is lost or duplicated.
//   reset clears every rail's average and peak to zero at once (valid bits,
//   no clearing pass); a rail index beyond the rail count leaves the store
//   alone and reports zero average and peak.
module rail_power_telemetry (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptel_in_if.sink    in_i,
  ptel_out_if.source out_o
);

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIFF  = 2'd1;
  localparam logic [1:0] S_SCALE = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               in_xfer, out_free, write_go;
  logic [2:0]         rail_q;
  logic signed [15:0] cur_q, volt_q;
  logic               in_range_q, in_range;
  logic               out_valid_q;
  ptel_pkg::result_t  out_q;
  ptel_pkg::stage_t   stage;

  ptel_pkg::avg_t     rd_avg, avg_new;
  ptel_pkg::peak_t    rd_peak, peak_new;
  ptel_pkg::power_t   power, avg_int;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign write_go   = (state_q == S_WRITE) && out_free;
  assign in_range   = 32'(in_i.rail) < ptel_pkg::RAIL_COUNT;

  // datapath step enables follow the sequencer
  assign stage.mul   = in_xfer;
  assign stage.diff  = (state_q == S_DIFF);
  assign stage.scale = (state_q == S_SCALE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF:  state_d = S_SCALE;
      S_SCALE: state_d = S_WRITE;
      S_WRITE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      in_range_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        in_range_q <= in_range;
      end
      if (write_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item fields held for the echo
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rail_q <= in_i.rail;
      cur_q  <= in_i.shunt_sample;
      volt_q <= in_i.bus_sample;
    end
    if (write_go) begin
      out_q.rail_out           <= rail_q;
      out_q.current_quarter_ma <= cur_q;
      out_q.voltage_mv         <= volt_q;
      out_q.power_now          <= power;
      out_q.power_average      <= in_range_q ? avg_int : '0;
      out_q.power_peak         <= in_range_q ? peak_new : '0;
    end
  end

  ptel_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_idx_i  (ptel_pkg::RAIL_IDX_W'(in_i.rail)),
    .rd_avg_o  (rd_avg),
    .rd_peak_o (rd_peak),
    .wr_en_i   (write_go && in_range_q),
    .wr_idx_i  (ptel_pkg::RAIL_IDX_W'(rail_q)),
    .wr_avg_i  (avg_new),
    .wr_peak_i (peak_new)
  );

  ptel_ema u_ema (
    .clk_i      (clk_i),
    .stage_i    (stage),
    .shunt_i    (in_i.shunt_sample),
    .bus_i      (in_i.bus_sample),
    .avg_i      (rd_avg),
    .peak_i     (rd_peak),
    .power_o    (power),
    .avg_new_o  (avg_new),
    .peak_new_o (peak_new),
    .avg_int_o  (avg_int)
  );

  assign out_o.valid              = out_valid_q;
  assign out_o.rail_out           = out_q.rail_out;
  assign out_o.current_quarter_ma = out_q.current_quarter_ma;
  assign out_o.voltage_mv         = out_q.voltage_mv;
  assign out_o.power_now          = out_q.power_now;
  assign out_o.power_average      = out_q.power_average;
  assign out_o.power_peak         = out_q.power_peak;

  // every input transfer reaches write-back by way of the difference and scale steps
  a_fixed_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##3 (state_q == S_WRITE))
    else $error("item did not reach write-back on schedule");

  // a new result only ever comes from the write-back step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WRITE))
    else $error("result appeared outside write-back");

  // the stored peak never falls
  a_peak_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_go && in_range_q) |-> (peak_new >= rd_peak))
    else $error("peak decreased");

  // store is never read while an item is in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_xfer)
    else $error("input taken while an item is in flight");

endmodule

/* design/ptel_store.sv */
// ptel_store: per-rail average and peak memory, registered read
// depends on ptel_pkg; entries never written since reset read as zero
module ptel_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  ptel_pkg::rail_idx_t rd_idx_i,
  output ptel_pkg::avg_t      rd_avg_o,
  output ptel_pkg::peak_t     rd_peak_o,
  input  logic                wr_en_i,
  input  ptel_pkg::rail_idx_t wr_idx_i,
  input  ptel_pkg::avg_t      wr_avg_i,
  input  ptel_pkg::peak_t     wr_peak_i
);

  localparam int WORD_W = ptel_pkg::AVG_W + ptel_pkg::PEAK_W;

  logic [WORD_W-1:0]               mem [ptel_pkg::RAIL_COUNT];
  logic [ptel_pkg::RAIL_COUNT-1:0] valid_q;
  logic [WORD_W-1:0]               rd_word_q;
  logic                            hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= {wr_avg_i, wr_peak_i};
    end
    if (rd_en_i) begin
      rd_word_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_avg_o  = hit_q ? ptel_pkg::avg_t'(rd_word_q[WORD_W-1:ptel_pkg::PEAK_W]) : '0;
  assign rd_peak_o = hit_q ? rd_word_q[ptel_pkg::PEAK_W-1:0] : '0;

endmodule

/* design/ptel_ema.sv */
// ptel_ema: power product, exponential average update and peak compare
// depends on ptel_pkg; steps are enabled by the top level sequencer
module ptel_ema (
  input  logic               clk_i,
  input  ptel_pkg::stage_t   stage_i,
  input  logic signed [15:0] shunt_i,
  input  logic signed [15:0] bus_i,
  input  ptel_pkg::avg_t     avg_i,
  input  ptel_pkg::peak_t    peak_i,
  output ptel_pkg::power_t   power_o,
  output ptel_pkg::avg_t     avg_new_o,
  output ptel_pkg::peak_t    peak_new_o,
  output ptel_pkg::power_t   avg_int_o
);

  localparam logic signed [ptel_pkg::HI_PROD_W-1:0] WEIGHT_S =
    ptel_pkg::HI_PROD_W'(ptel_pkg::EMA_WEIGHT);
  localparam logic [ptel_pkg::LO_PROD_W-1:0] WEIGHT_U =
    ptel_pkg::LO_PROD_W'(ptel_pkg::EMA_WEIGHT);

  ptel_pkg::power_t                        power_q;
  logic signed [ptel_pkg::DIFF_W-1:0]      diff_d, diff_q;
  logic signed [ptel_pkg::HI_W-1:0]        hi;
  logic signed [ptel_pkg::HI_PROD_W-1:0]   hi_prod_d, hi_prod_q;
  logic [ptel_pkg::LO_PROD_W-1:0]          lo_prod_d, lo_prod_q;
  logic [ptel_pkg::AVG_W-1:0]              hi_ext, lo_ext;
  logic signed [ptel_pkg::POWER_W-1:0]     peak_s;

  // diff = p * 2^frac - avg
  assign diff_d = (ptel_pkg::DIFF_W'(power_q) <<< ptel_pkg::AVG_FRAC_BITS)
                  - ptel_pkg::DIFF_W'(avg_i);

  // floor(diff * w / 2^16) split into whole and fraction parts of diff
  assign hi        = diff_q[ptel_pkg::DIFF_W-1:ptel_pkg::EMA_SHIFT];
  assign hi_prod_d = ptel_pkg::HI_PROD_W'(hi) * WEIGHT_S;
  assign lo_prod_d = ptel_pkg::LO_PROD_W'(diff_q[ptel_pkg::EMA_SHIFT-1:0]) * WEIGHT_U;

  always_ff @(posedge clk_i) begin
    if (stage_i.mul) begin
      power_q <= ptel_pkg::power_t'(shunt_i) * ptel_pkg::power_t'(bus_i);
    end
    if (stage_i.diff) begin
      diff_q <= diff_d;
    end
    if (stage_i.scale) begin
      hi_prod_q <= hi_prod_d;
      lo_prod_q <= lo_prod_d;
    end
  end

  assign hi_ext    = ptel_pkg::AVG_W'(hi_prod_q);
  assign lo_ext    = ptel_pkg::AVG_W'(lo_prod_q[ptel_pkg::LO_PROD_W-1:ptel_pkg::EMA_SHIFT]);
  assign avg_new_o = ptel_pkg::avg_t'(avg_i + hi_ext + lo_ext);
  assign avg_int_o = avg_new_o[ptel_pkg::AVG_FRAC_BITS +: ptel_pkg::POWER_W];

  assign peak_s     = $signed({1'b0, peak_i});
  assign peak_new_o = (power_q > peak_s) ? power_q[ptel_pkg::PEAK_W-1:0] : peak_i;
  assign power_o    = power_q;

endmodule
